[src/depl_pkg.sv]
// ----------------------------------------------------------------------------
// depl_pkg
// Shared widths, register indexes, reset values and the product saturation
// helper for the dual encoder PD position loop.
// ----------------------------------------------------------------------------
package depl_pkg;

  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int BAND_W     = 16;
  localparam int CUT_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_BAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_ERROR = 3'd5;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 16'd256;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = 16'd0;
  localparam logic [BAND_W-1:0] SETTLE_BAND_RST  = 16'd5;
  localparam logic [CUT_W-1:0]  CUTOFF_ERROR_RST = 31'd100000;
  localparam int                MAX_POWER_RST    = 255;
  localparam int                MIN_POWER_RST    = 0;

  localparam int MUL_W   = 32;
  localparam int OPA_W   = 2 * MUL_W;
  localparam int ACC_W   = 3 * MUL_W;
  localparam int SUM_W   = 64;
  localparam int CAP_W   = 62;
  localparam int SCALE_W = 20;
  localparam int U_SHIFT = 8;

  localparam logic [MUL_W-1:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [CAP_W-1:0] PROD_CAP     = 62'h2000_0000_0000_0000;
  localparam int               MIN_ERR_MAG  = 10;

  typedef logic [CAP_W-1:0] cap_t;

  function automatic cap_t sat_cap(input logic [ACC_W-1:0] v);
    sat_cap = (v > ACC_W'(PROD_CAP)) ? PROD_CAP : v[CAP_W-1:0];
  endfunction

endpackage

[src/depl_ifs.sv]
// ----------------------------------------------------------------------------
// depl_ifs
// Valid/ready channels of the position loop: encoder tick in, motor drive out.
// ----------------------------------------------------------------------------
interface depl_in_if #(parameter int COUNT_BITS = 32) ();
  logic                              valid;
  logic                              ready;
  logic [depl_pkg::TIME_W-1:0]       time_us;
  logic signed [COUNT_BITS-1:0]      count_left;
  logic signed [COUNT_BITS-1:0]      count_right;
  logic signed [COUNT_BITS-1:0]      goal_left;
  logic signed [COUNT_BITS-1:0]      goal_right;

  modport source (
    output valid, time_us, count_left, count_right, goal_left, goal_right,
    input  ready
  );
  modport sink (
    input  valid, time_us, count_left, count_right, goal_left, goal_right,
    output ready
  );
endinterface

interface depl_out_if #(parameter int POWER_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [POWER_BITS-1:0] power_left;
  logic                  reverse_left;
  logic [POWER_BITS-1:0] power_right;
  logic                  reverse_right;
  logic                  target_reached;
  logic                  cutoff_tripped;

  modport source (
    output valid, power_left, reverse_left, power_right, reverse_right,
           target_reached, cutoff_tripped,
    input  ready
  );
  modport sink (
    input  valid, power_left, reverse_left, power_right, reverse_right,
           target_reached, cutoff_tripped,
    output ready
  );
endinterface

[src/dual_encoder_pd_position_loop.sv]
// ----------------------------------------------------------------------------
// dual_encoder_pd_position_loop
// Two-motor saturated PD position loop with settle and cutoff overrides.
// ----------------------------------------------------------------------------
// Each input beat carries a timestamp, two encoder counts and two targets, and
// yields one result beat with a power magnitude and direction per motor plus
// the settle and cutoff flags. The motors are worked one after the other on a
// single 32x32 multiplier and a restoring divider that retires one quotient bit
// per cycle over its COUNT_BITS+21 steps per motor. The input is taken again
// in the cycle after the result is registered, while that result waits for
// the sink.
module dual_encoder_pd_position_loop #(
  parameter int POWER_BITS = 12,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  depl_in_if.sink                           in_ch,
  depl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [depl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [depl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ERR_W  = COUNT_BITS + 1;
  localparam int EMAG_W = COUNT_BITS;
  localparam int DE_W   = COUNT_BITS + 2;
  localparam int DMAG_W = COUNT_BITS + 1;
  localparam int NUM_W  = DMAG_W + depl_pkg::SCALE_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int CMP_W  = (EMAG_W > depl_pkg::CUT_W) ? EMAG_W : depl_pkg::CUT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_MUL_LO = 4'd2;
  localparam logic [3:0] S_MUL_HI = 4'd3;
  localparam logic [3:0] S_DLOAD  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DSAT   = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_PWR    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam logic [1:0] SEL_SCALE = 2'd0;
  localparam logic [1:0] SEL_PROP  = 2'd1;
  localparam logic [1:0] SEL_DERIV = 2'd2;

  logic [depl_pkg::GAIN_W-1:0]  prop_gain_r;
  logic [depl_pkg::GAIN_W-1:0]  deriv_gain_r;
  logic [POWER_BITS-1:0]        max_power_r;
  logic [POWER_BITS-1:0]        min_power_r;
  logic [depl_pkg::BAND_W-1:0]  settle_band_r;
  logic [depl_pkg::CUT_W-1:0]   cutoff_error_r;

  logic [3:0]                   state_r;
  logic [3:0]                   state_nxt;
  logic                         ax_r;
  logic [1:0]                   sel_r;
  logic [DCNT_W-1:0]            div_cnt_r;

  logic signed [ERR_W-1:0]      err_r      [2];
  logic signed [ERR_W-1:0]      last_err_r [2];
  logic [EMAG_W-1:0]            emag_r     [2];
  logic [depl_pkg::TIME_W-1:0]  last_time_r;
  logic [depl_pkg::TIME_W-1:0]  dt_r;
  logic                         e_neg_r;
  logic                         de_neg_r;
  logic [DMAG_W-1:0]            de_mag_r;

  logic [depl_pkg::ACC_W-1:0]   acc_r;
  logic [NUM_W-1:0]             num_r;
  logic [depl_pkg::TIME_W-1:0]  rem_r;
  depl_pkg::cap_t               dmag_r;
  depl_pkg::cap_t               pmag_r;
  depl_pkg::cap_t               dprod_r;
  logic [depl_pkg::SUM_W-1:0]   s_r;
  logic [POWER_BITS-1:0]        pwr_r [2];
  logic                         rev_r [2];

  logic                         out_valid_r;
  logic [POWER_BITS-1:0]        power_left_r;
  logic                         reverse_left_r;
  logic [POWER_BITS-1:0]        power_right_r;
  logic                         reverse_right_r;
  logic                         target_reached_r;
  logic                         cutoff_tripped_r;

  logic                         in_take;
  logic                         out_free;
  logic                         div_last;

  logic signed [ERR_W-1:0]      err_cur;
  logic signed [DE_W-1:0]       de_cur;
  logic [EMAG_W-1:0]            emag_cur;
  logic [DMAG_W-1:0]            de_mag_cur;

  logic [depl_pkg::OPA_W-1:0]   opa;
  logic [depl_pkg::MUL_W-1:0]   opb;
  logic [depl_pkg::MUL_W-1:0]   opa_half;
  logic [2*depl_pkg::MUL_W-1:0] prod;

  logic [depl_pkg::TIME_W:0]    div_rs;
  logic [depl_pkg::TIME_W:0]    div_diff;
  logic                         div_ge;

  logic [depl_pkg::SUM_W-1:0]   p_term;
  logic [depl_pkg::SUM_W-1:0]   s_cur;
  logic [depl_pkg::SUM_W-1:0]   u_mag;
  logic [POWER_BITS-1:0]        pwr_cur;

  logic                         reached;
  logic                         tripped;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign div_last    = (div_cnt_r == DCNT_W'(NUM_W - 1));

  assign err_cur    = err_r[ax_r];
  assign de_cur     = DE_W'(err_cur) - DE_W'(last_err_r[ax_r]);
  assign emag_cur   = EMAG_W'(err_cur[ERR_W-1] ? -err_cur : err_cur);
  assign de_mag_cur = DMAG_W'(de_cur[DE_W-1] ? -de_cur : de_cur);

  always_comb begin
    unique case (sel_r)
      SEL_SCALE: begin
        opa = depl_pkg::OPA_W'(de_mag_r);
        opb = depl_pkg::USEC_PER_SEC;
      end
      SEL_PROP: begin
        opa = depl_pkg::OPA_W'(emag_r[ax_r]);
        opb = depl_pkg::MUL_W'(prop_gain_r);
      end
      SEL_DERIV: begin
        opa = depl_pkg::OPA_W'(dmag_r);
        opb = depl_pkg::MUL_W'(deriv_gain_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign opa_half = (state_r == S_MUL_HI) ? opa[depl_pkg::OPA_W-1:depl_pkg::MUL_W]
                                          : opa[depl_pkg::MUL_W-1:0];
  assign prod     = opa_half * opb;

  assign div_rs   = {rem_r, num_r[NUM_W-1]};
  assign div_diff = div_rs - {1'b0, dt_r};
  assign div_ge   = !div_diff[depl_pkg::TIME_W];

  always_comb begin
    p_term = e_neg_r ? -depl_pkg::SUM_W'(pmag_r) : depl_pkg::SUM_W'(pmag_r);
    s_cur  = de_neg_r ? p_term - depl_pkg::SUM_W'(dprod_r)
                      : p_term + depl_pkg::SUM_W'(dprod_r);
  end

  always_comb begin
    if (s_r[depl_pkg::SUM_W-1]) begin
      u_mag = (~s_r + depl_pkg::SUM_W'(256)) >> depl_pkg::U_SHIFT;
    end else begin
      u_mag = s_r >> depl_pkg::U_SHIFT;
    end
    if (u_mag > depl_pkg::SUM_W'(max_power_r)) begin
      pwr_cur = max_power_r;
    end else if (u_mag < depl_pkg::SUM_W'(min_power_r) &&
                 emag_r[ax_r] > EMAG_W'(depl_pkg::MIN_ERR_MAG)) begin
      pwr_cur = min_power_r;
    end else begin
      pwr_cur = u_mag[POWER_BITS-1:0];
    end
  end

  assign reached = (CMP_W'(emag_r[0]) < CMP_W'(settle_band_r)) &&
                   (CMP_W'(emag_r[1]) < CMP_W'(settle_band_r));
  assign tripped = !reached &&
                   ((CMP_W'(emag_r[0]) > CMP_W'(cutoff_error_r)) ||
                    (CMP_W'(emag_r[1]) > CMP_W'(cutoff_error_r)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_ERR;
      S_ERR:    state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: begin
        unique case (sel_r)
          SEL_SCALE: state_nxt = S_DLOAD;
          SEL_PROP:  state_nxt = S_MUL_LO;
          default:   state_nxt = S_DSAT;
        endcase
      end
      S_DLOAD:  state_nxt = S_DIV;
      S_DIV:    if (div_last) state_nxt = S_MUL_LO;
      S_DSAT:   state_nxt = S_SUM;
      S_SUM:    state_nxt = S_PWR;
      S_PWR:    state_nxt = ax_r ? S_FIN : S_ERR;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= depl_pkg::PROP_GAIN_RST;
      deriv_gain_r   <= depl_pkg::DERIV_GAIN_RST;
      max_power_r    <= POWER_BITS'(depl_pkg::MAX_POWER_RST);
      min_power_r    <= POWER_BITS'(depl_pkg::MIN_POWER_RST);
      settle_band_r  <= depl_pkg::SETTLE_BAND_RST;
      cutoff_error_r <= depl_pkg::CUTOFF_ERROR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        depl_pkg::REG_PROP_GAIN:    prop_gain_r    <= cfg_data[depl_pkg::GAIN_W-1:0];
        depl_pkg::REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data[depl_pkg::GAIN_W-1:0];
        depl_pkg::REG_MAX_POWER:    max_power_r    <= cfg_data[POWER_BITS-1:0];
        depl_pkg::REG_MIN_POWER:    min_power_r    <= cfg_data[POWER_BITS-1:0];
        depl_pkg::REG_SETTLE_BAND:  settle_band_r  <= cfg_data[depl_pkg::BAND_W-1:0];
        depl_pkg::REG_CUTOFF_ERROR: cutoff_error_r <= cfg_data[depl_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      last_time_r   <= '0;
      last_err_r[0] <= '0;
      last_err_r[1] <= '0;
      ax_r          <= 1'b0;
      sel_r         <= SEL_SCALE;
      div_cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_take) begin
        last_time_r <= in_ch.time_us;
        ax_r        <= 1'b0;
      end

      if (state_r == S_ERR) begin
        last_err_r[ax_r] <= err_cur;
        sel_r            <= SEL_SCALE;
      end

      if (state_r == S_MUL_HI && sel_r == SEL_PROP) begin
        sel_r <= SEL_DERIV;
      end

      if (state_r == S_DLOAD) begin
        div_cnt_r <= '0;
      end

      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + DCNT_W'(1);
        if (div_last) begin
          sel_r <= SEL_PROP;
        end
      end

      if (state_r == S_PWR && !ax_r) begin
        ax_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      err_r[0] <= ERR_W'(in_ch.count_left) - ERR_W'(in_ch.goal_left);
      err_r[1] <= ERR_W'(in_ch.count_right) - ERR_W'(in_ch.goal_right);
      dt_r     <= in_ch.time_us - last_time_r;
    end

    unique case (state_r)
      S_ERR: begin
        e_neg_r      <= err_cur[ERR_W-1];
        emag_r[ax_r] <= emag_cur;
        de_neg_r     <= de_cur[DE_W-1];
        de_mag_r     <= de_mag_cur;
      end
      S_MUL_LO: begin
        acc_r <= depl_pkg::ACC_W'(prod);
        if (sel_r == SEL_PROP) begin
          dmag_r <= (dt_r == '0) ? '0 : depl_pkg::sat_cap(depl_pkg::ACC_W'(num_r));
        end
        if (sel_r == SEL_DERIV) begin
          pmag_r <= depl_pkg::sat_cap(acc_r);
        end
      end
      S_MUL_HI: begin
        acc_r <= acc_r + {prod, {depl_pkg::MUL_W{1'b0}}};
      end
      S_DLOAD: begin
        num_r <= acc_r[NUM_W-1:0];
        rem_r <= '0;
      end
      S_DIV: begin
        num_r <= {num_r[NUM_W-2:0], div_ge};
        rem_r <= div_ge ? div_diff[depl_pkg::TIME_W-1:0] : div_rs[depl_pkg::TIME_W-1:0];
      end
      S_DSAT: begin
        dprod_r <= depl_pkg::sat_cap(acc_r);
      end
      S_SUM: begin
        s_r <= s_cur;
      end
      S_PWR: begin
        pwr_r[ax_r] <= pwr_cur;
        rev_r[ax_r] <= s_r[depl_pkg::SUM_W-1];
      end
      S_FIN: begin
        if (out_free) begin
          power_left_r     <= (reached || tripped) ? '0 : pwr_r[0];
          reverse_left_r   <= rev_r[0];
          power_right_r    <= (reached || tripped) ? '0 : pwr_r[1];
          reverse_right_r  <= rev_r[1];
          target_reached_r <= reached;
          cutoff_tripped_r <= tripped;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.power_left     = power_left_r;
  assign out_ch.reverse_left   = reverse_left_r;
  assign out_ch.power_right    = power_right_r;
  assign out_ch.reverse_right  = reverse_right_r;
  assign out_ch.target_reached = target_reached_r;
  assign out_ch.cutoff_tripped = cutoff_tripped_r;

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("Result beat raised outside the finish step.");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_ERR && !ax_r))
    else $error("Accepted beat did not start the left motor.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(target_reached_r && cutoff_tripped_r))
    else $error("Settle and cutoff flags raised together.");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (target_reached_r || cutoff_tripped_r)) |->
      (power_left_r == '0 && power_right_r == '0))
    else $error("Motor power nonzero while stopped.");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < DCNT_W'(NUM_W)))
    else $error("Divider step count overran.");

endmodule
